@@ rtl/ipv4_tcp_checksum_generator_macros.svh @@
`ifndef IPV4_TCP_CHECKSUM_GENERATOR_MACROS_SVH
`define IPV4_TCP_CHECKSUM_GENERATOR_MACROS_SVH

// checked only once reset has been released
`define ITCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ITCG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/itcg_pkg.sv @@
`default_nettype none

package itcg_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } itcg_in_t;

    typedef struct packed {
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
        logic        is_tcp;
        logic        length_error;
    } itcg_out_t;

    typedef struct packed {
        logic     valid;
        itcg_in_t item;
    } itcg_stage_t;

    // end-around carry add, never overflows 16 bits
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipv4_tcp_checksum_generator.sv @@
// IPv4 header and TCP checksum generator.
// request channel: req_valid / req_stall / req, one packet byte per request in
// network order, req.last on the final byte of the buffer.
// result channel: res_valid / res_stall / res, one result per packet, issued for
// the request that carries last: ip_checksum, tcp_checksum, is_tcp, length_error.
// a request is registered at the edge that accepts it; its sums are formed
// combinationally from the request register and a last byte then loads the result
// register, which raises res_valid, unless an earlier result is held by res_stall.
// throughput is one byte per cycle unless a last byte waits on such a held result,
// set by the 16-bit end-around adds that each byte feeds in parallel.
// while a result waits under res_stall, bytes without last keep flowing; only a
// further last byte is held in the request register, which then raises req_stall.
// reset clears the packet state, the valid flags and any pending result; the next
// byte after reset or after a last byte is taken as byte 0 of a new packet.
`default_nettype none

module ipv4_tcp_checksum_generator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire itcg_pkg::itcg_in_t   req,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output itcg_pkg::itcg_out_t       res
);

    itcg_pkg::itcg_stage_t stage;
    itcg_pkg::itcg_out_t   result;
    logic                  busy;
    logic                  fire;
    logic                  load;

    assign fire = stage.valid && (!stage.item.last || !busy);
    assign load = fire && stage.item.last;

    itcg_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .fire      (fire),
        .stage     (stage)
    );

    itcg_sum u_sum (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (stage.item),
        .result (result)
    );

    itcg_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (result),
        .busy      (busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ rtl/itcg_in_stage.sv @@
`default_nettype none

module itcg_in_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire itcg_pkg::itcg_in_t    req,
    input  wire logic                  fire,
    output itcg_pkg::itcg_stage_t      stage
);

    logic               valid_reg;
    logic               valid_next;
    itcg_pkg::itcg_in_t item_reg;
    logic               accept;

    assign req_stall = valid_reg && !fire;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

@@ rtl/itcg_sum.sv @@
`default_nettype none

module itcg_sum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire itcg_pkg::itcg_in_t  item,
    output itcg_pkg::itcg_out_t      result
);

    localparam logic [15:0] POS_IHL      = 16'd0;
    localparam logic [15:0] POS_TLEN_HI  = 16'd2;
    localparam logic [15:0] POS_TLEN_LO  = 16'd3;
    localparam logic [15:0] POS_PROTO    = 16'd9;
    localparam logic [15:0] POS_IPCK_HI  = 16'd10;
    localparam logic [15:0] POS_IPCK_LO  = 16'd11;
    localparam logic [15:0] POS_SRC_ADDR = 16'd12;
    localparam logic [15:0] POS_HDR_MIN  = 16'd20;
    localparam logic [15:0] TCPCK_OFFSET = 16'd16;
    localparam logic [16:0] MIN_BYTES    = 17'd4;
    localparam logic [3:0]  MIN_IHL      = 4'd5;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    logic [15:0] pos_reg, pos_next;
    logic [3:0]  hw_reg, hw_next;
    logic [15:0] tl_reg, tl_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [15:0] seg_reg, seg_next;
    logic        tcp_reg, tcp_next;

    logic [7:0]  b;
    logic [15:0] hl;
    logic [15:0] w;
    logic        counted;
    logic        in_hdr;
    logic        hdr_add;
    logic        seg_add;
    logic [16:0] received;
    logic        err;
    logic [15:0] l4len;
    logic [15:0] pseudo;
    logic [15:0] tcp_sum;

    assign b = item.data_byte;

    always_comb
    begin
        hw_next  = (pos_reg == POS_IHL) ? b[3:0] : hw_reg;
        tcp_next = (pos_reg == POS_PROTO) ? (b == PROTO_TCP) : tcp_reg;
        case (pos_reg)
            POS_TLEN_HI: tl_next = {b, 8'd0};
            POS_TLEN_LO: tl_next = tl_reg | {8'd0, b};
            default:     tl_next = tl_reg;
        endcase

        hl      = {10'd0, hw_next, 2'b00};
        w       = pos_reg[0] ? {8'd0, b} : {b, 8'd0};
        counted = ({1'b0, pos_reg} < MIN_BYTES) || (pos_reg < tl_next);
        in_hdr  = pos_reg < hl;
        hdr_add = counted && in_hdr && (pos_reg != POS_IPCK_HI) && (pos_reg != POS_IPCK_LO);
        if (in_hdr)
        begin
            seg_add = counted && (pos_reg >= POS_SRC_ADDR) && (pos_reg < POS_HDR_MIN);
        end
        else
        begin
            seg_add = counted && (pos_reg != hl + TCPCK_OFFSET)
                    && (pos_reg != hl + TCPCK_OFFSET + 16'd1);
        end

        hdr_next = hdr_add ? itcg_pkg::ones_add(hdr_reg, w) : hdr_reg;
        seg_next = seg_add ? itcg_pkg::ones_add(seg_reg, w) : seg_reg;
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;

        received = {1'b0, pos_reg} + 17'd1;
        err      = (hw_next < MIN_IHL) || (received < MIN_BYTES) || (tl_next < hl)
                 || (received < {1'b0, tl_next});
        l4len    = tl_next - hl;
        pseudo   = itcg_pkg::ones_add({8'd0, PROTO_TCP}, l4len);
        tcp_sum  = itcg_pkg::ones_add(seg_next, pseudo);

        result.ip_checksum  = err ? 16'd0 : ~hdr_next;
        result.tcp_checksum = (err || !tcp_next) ? 16'd0 : ~tcp_sum;
        result.is_tcp       = tcp_next;
        result.length_error = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hw_reg  <= '0;
            tl_reg  <= '0;
            hdr_reg <= '0;
            seg_reg <= '0;
            tcp_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                pos_reg <= '0;
                hw_reg  <= '0;
                tl_reg  <= '0;
                hdr_reg <= '0;
                seg_reg <= '0;
                tcp_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                hw_reg  <= hw_next;
                tl_reg  <= tl_next;
                hdr_reg <= hdr_next;
                seg_reg <= seg_next;
                tcp_reg <= tcp_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/itcg_out_stage.sv @@
`default_nettype none

module itcg_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire itcg_pkg::itcg_out_t  result,
    output logic                      busy,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output itcg_pkg::itcg_out_t       res
);

    logic                valid_reg;
    logic                valid_next;
    itcg_pkg::itcg_out_t res_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign busy      = valid_reg && res_stall;
    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ rtl/itcg_checker.sv @@
`default_nettype none

`include "ipv4_tcp_checksum_generator_macros.svh"

module itcg_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_stall,
    input wire logic                 res_valid,
    input wire logic                 res_stall,
    input wire itcg_pkg::itcg_out_t  res
);

    `ITCG_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !res_valid, "result valid during reset")
    `ITCG_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result moved")
    `ITCG_ASSERT(a_err_zero, res_valid && res.length_error |-> {res.ip_checksum,
        res.tcp_checksum} == 32'd0, "checksum on length error")
    `ITCG_ASSERT(a_non_tcp_zero, res_valid && !res.is_tcp |-> res.tcp_checksum == 16'd0,
        "tcp checksum without tcp")
    `ITCG_ASSERT(a_stall_cause, req_stall |-> res_valid && res_stall, "request stalled idly")

endmodule

bind ipv4_tcp_checksum_generator itcg_checker u_itcg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
